// ===== rtl/rgb_to_hsl_converter_unit_macros.svh =====
// assertion macros for the rgb to hsl converter
// used by the top level only; expects clk and arst_n in scope
`ifndef RGB_TO_HSL_CONVERTER_UNIT_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define RHSL_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rhsl assertion failed");

// next-cycle implication, off during reset
`define RHSL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rhsl assertion failed");

`endif

// ===== rtl/rhsl_pkg.sv =====
// shared types and constants for the rgb to hsl converter
// no dependencies
package rhsl_pkg;

	localparam int ChanW         = 8;
	localparam int FracW         = 16;
	localparam int SatNumW       = 24;
	localparam int HueDenW       = 11;
	localparam int StepsPerStage = 4;
	localparam int DivStages     = SatNumW / StepsPerStage;
	localparam int HueStages     = FracW / StepsPerStage;

	typedef struct packed {
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [FracW-1:0] hue;
		logic [FracW-1:0] saturation;
		logic [FracW-1:0] lightness;
	} hsl_t;

	typedef struct packed {
		pixel_t           pix;
		logic [ChanW-1:0] mx;
		logic [ChanW-1:0] mn;
	} minmax_t;

	// state of both long divisions as it moves down the pipe
	typedef struct packed {
		logic [SatNumW-1:0] sat_num;
		logic [ChanW-1:0]   sat_den;
		logic [ChanW-1:0]   sat_rem;
		logic [FracW-1:0]   sat_q;
		logic [HueDenW-1:0] hue_den;
		logic [HueDenW-1:0] hue_rem;
		logic [FracW-1:0]   hue_q;
		logic [FracW-1:0]   light;
	} div_t;

endpackage

// ===== rtl/rgb_to_hsl_converter_unit.sv =====
// rgb to hsl converter, top level
// depends on rhsl_pkg, rhsl_minmax, rhsl_prep, rhsl_div_stage and the macros header
//
// usage:
//   pix_valid/pix_ready/pix take one 8-bit rgb pixel per item.
//   hsl_valid/hsl_ready/hsl give hue (turn * 65536, wraps), saturation and
//   lightness (both * 65535), one item out for each item in, in order.
// timing:
//   eight register stages: min/max, operand prep, then six divider stages of
//   four restoring steps each (24 saturation quotient steps, 16 hue steps).
//   throughput is one item per cycle while hsl_ready is high; each stage has
//   its own valid bit, so empty stages fill up even while the output is held.
// reset:
//   arst_n clears all valid bits; the pipe comes out empty and ready.
// stall:
//   when hsl_ready is low the output holds, as does each full stage whose
//   next stage holds; pix_ready drops only once no stage in front of the input can move.
`include "rgb_to_hsl_converter_unit_macros.svh"

module rgb_to_hsl_converter_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	output logic             pix_ready,
	input  rhsl_pkg::pixel_t pix,
	output logic             hsl_valid,
	input  logic             hsl_ready,
	output rhsl_pkg::hsl_t   hsl
);

	logic              mm_valid;
	logic              mm_ready;
	rhsl_pkg::minmax_t mm_data;

	logic           dv_valid [rhsl_pkg::DivStages+1];
	logic           dv_ready [rhsl_pkg::DivStages+1];
	rhsl_pkg::div_t dv_data  [rhsl_pkg::DivStages+1];

	rhsl_minmax u_minmax (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_valid),
		.in_ready  (pix_ready),
		.in_data   (pix),
		.out_valid (mm_valid),
		.out_ready (mm_ready),
		.out_data  (mm_data)
	);

	rhsl_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mm_valid),
		.in_ready  (mm_ready),
		.in_data   (mm_data),
		.out_valid (dv_valid[0]),
		.out_ready (dv_ready[0]),
		.out_data  (dv_data[0])
	);

	for (genvar k = 0; k < rhsl_pkg::DivStages; k++) begin : g_div
		rhsl_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.hue_en    (k < rhsl_pkg::HueStages),
			.in_valid  (dv_valid[k]),
			.in_ready  (dv_ready[k]),
			.in_data   (dv_data[k]),
			.out_valid (dv_valid[k+1]),
			.out_ready (dv_ready[k+1]),
			.out_data  (dv_data[k+1])
		);
	end

	assign hsl_valid                      = dv_valid[rhsl_pkg::DivStages];
	assign dv_ready[rhsl_pkg::DivStages]  = hsl_ready;
	assign hsl.hue        = dv_data[rhsl_pkg::DivStages].hue_q;
	assign hsl.saturation = dv_data[rhsl_pkg::DivStages].sat_q;
	assign hsl.lightness  = dv_data[rhsl_pkg::DivStages].light;

	// any nonzero chroma gives saturation of at least 257, so zero means grey
	`RHSL_ASSERT_IMPLY(a_grey_hue_zero, hsl_valid && hsl.saturation == '0, hsl.hue == '0)
	`RHSL_ASSERT_IMPLY(a_black_sat_zero, hsl_valid && hsl.lightness == '0,
		hsl.saturation == '0)
	// a ready sink lets every stage move, so the input is open
	`RHSL_ASSERT_IMPLY(a_ready_chain, hsl_ready, pix_ready)

endmodule

// ===== rtl/rhsl_minmax.sv =====
// first stage: channel max and min of the pixel
// depends on rhsl_pkg
module rhsl_minmax (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rhsl_pkg::pixel_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output rhsl_pkg::minmax_t out_data
);

	logic              valid_s1;
	rhsl_pkg::minmax_t data_s1;
	rhsl_pkg::minmax_t nxt;
	logic [rhsl_pkg::ChanW-1:0] rg_max;
	logic [rhsl_pkg::ChanW-1:0] rg_min;

	always_comb begin
		rg_max = (in_data.red > in_data.green) ? in_data.red : in_data.green;
		rg_min = (in_data.red < in_data.green) ? in_data.red : in_data.green;
		nxt.pix = in_data;
		nxt.mx  = (rg_max > in_data.blue) ? rg_max : in_data.blue;
		nxt.mn  = (rg_min < in_data.blue) ? rg_min : in_data.blue;
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ===== rtl/rhsl_prep.sv =====
// second stage: lightness, and numerators and divisors for saturation and hue
// depends on rhsl_pkg
module rhsl_prep (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rhsl_pkg::minmax_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rhsl_pkg::div_t    out_data
);

	logic           valid_s2;
	rhsl_pkg::div_t data_s2;
	rhsl_pkg::div_t nxt;

	logic [rhsl_pkg::ChanW:0]     sum;
	logic [rhsl_pkg::ChanW-1:0]   d;
	logic [rhsl_pkg::ChanW-1:0]   xr;
	logic [rhsl_pkg::ChanW-1:0]   xg;
	logic [rhsl_pkg::ChanW-1:0]   xb;
	logic [rhsl_pkg::HueDenW-1:0] dw;
	logic [rhsl_pkg::HueDenW-1:0] den6;
	logic [rhsl_pkg::HueDenW-1:0] num;
	logic [rhsl_pkg::FracW:0]     light_x2;

	always_comb begin
		sum  = {1'b0, in_data.mx} + {1'b0, in_data.mn};
		d    = in_data.mx - in_data.mn;
		xr   = in_data.mx - in_data.pix.red;
		xg   = in_data.mx - in_data.pix.green;
		xb   = in_data.mx - in_data.pix.blue;
		dw   = {3'b000, d};
		den6 = (dw << 2) + (dw << 1);

		// sextant numerator over d, red then green win max ties
		if (in_data.pix.red == in_data.mx) begin
			if (in_data.pix.green == in_data.mn) begin
				num = (dw << 2) + dw + {3'b000, xb};
			end else begin
				num = dw - {3'b000, xg};
			end
		end else if (in_data.pix.green == in_data.mx) begin
			if (in_data.pix.blue == in_data.mn) begin
				num = dw + {3'b000, xr};
			end else begin
				num = (dw << 1) + dw - {3'b000, xb};
			end
		end else begin
			if (in_data.pix.red == in_data.mn) begin
				num = (dw << 1) + dw + {3'b000, xg};
			end else begin
				num = (dw << 2) + dw - {3'b000, xr};
			end
		end

		// sum * 65535 / 510 is sum * 257 / 2
		light_x2  = {sum, 8'h00} + {8'h00, sum};
		nxt.light = light_x2[rhsl_pkg::FracW:1];
		nxt.sat_q = '0;
		nxt.hue_q = '0;
		nxt.sat_rem = '0;

		if (d == '0) begin
			// grey or black: divide zero by one
			nxt.sat_num = '0;
			nxt.sat_den = 8'd1;
			nxt.hue_rem = '0;
			nxt.hue_den = 11'd1;
		end else begin
			nxt.sat_num = {d, 16'h0000} - {16'h0000, d};
			nxt.sat_den = sum[rhsl_pkg::ChanW] ? 8'(10'd510 - {1'b0, sum}) : sum[7:0];
			// a full turn wraps, so only the fraction below one is divided out
			nxt.hue_rem = (num == den6) ? '0 : num;
			nxt.hue_den = den6;
		end
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ===== rtl/rhsl_div_stage.sv =====
// one divider stage: four restoring steps of the saturation and, with hue_en, hue divisions
// depends on rhsl_pkg
module rhsl_div_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           hue_en,
	input  logic           in_valid,
	output logic           in_ready,
	input  rhsl_pkg::div_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output rhsl_pkg::div_t out_data
);

	// _sn: register of whichever divider stage this instance is
	logic           valid_sn;
	rhsl_pkg::div_t data_sn;
	rhsl_pkg::div_t cur;

	always_comb begin
		logic [rhsl_pkg::ChanW:0]   sat_sh;
		logic [rhsl_pkg::HueDenW:0] hue_sh;
		cur = in_data;
		for (int i = 0; i < rhsl_pkg::StepsPerStage; i++) begin
			// saturation: next numerator bit into the remainder
			sat_sh      = {cur.sat_rem, cur.sat_num[rhsl_pkg::SatNumW-1]};
			cur.sat_num = {cur.sat_num[rhsl_pkg::SatNumW-2:0], 1'b0};
			if (sat_sh >= {1'b0, cur.sat_den}) begin
				cur.sat_rem = 8'(sat_sh - {1'b0, cur.sat_den});
				cur.sat_q   = {cur.sat_q[rhsl_pkg::FracW-2:0], 1'b1};
			end else begin
				cur.sat_rem = sat_sh[rhsl_pkg::ChanW-1:0];
				cur.sat_q   = {cur.sat_q[rhsl_pkg::FracW-2:0], 1'b0};
			end
			// hue: fraction bits, zeros shifted in
			if (hue_en) begin
				hue_sh = {cur.hue_rem, 1'b0};
				if (hue_sh >= {1'b0, cur.hue_den}) begin
					cur.hue_rem = 11'(hue_sh - {1'b0, cur.hue_den});
					cur.hue_q   = {cur.hue_q[rhsl_pkg::FracW-2:0], 1'b1};
				end else begin
					cur.hue_rem = hue_sh[rhsl_pkg::HueDenW-1:0];
					cur.hue_q   = {cur.hue_q[rhsl_pkg::FracW-2:0], 1'b0};
				end
			end
		end
	end

	assign in_ready = !valid_sn || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (in_ready) begin
			valid_sn <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_sn <= cur;
		end
	end

	assign out_valid = valid_sn;
	assign out_data  = data_sn;

endmodule
